// ----- rtl/varint_zigzag_serializer_macros.svh -----
// Assertion macros shared by the serializer modules.
`ifndef VARINT_ZIGZAG_SERIALIZER_MACROS_SVH
`define VARINT_ZIGZAG_SERIALIZER_MACROS_SVH

`ifndef SYNTH
`define VZS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("serializer assertion failed");
`define VZS_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("serializer forbidden condition");
`else
`define VZS_ASSERT(label, prop)
`define VZS_NEVER(label, cond)
`endif

`endif

// ----- rtl/vzs_pkg.sv -----
// Shared types and constants of the varint / zigzag serializer.
`timescale 1ns / 1ps
package vzs_pkg;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned NB_W = 4;
	localparam int unsigned MAX_BYTES = 10;

	typedef enum logic [2:0] {
		CMD_FIX8   = 3'd0,
		CMD_FIX16  = 3'd1,
		CMD_FIX32  = 3'd2,
		CMD_FIX64  = 3'd3,
		CMD_UVAR32 = 3'd4,
		CMD_SVAR32 = 3'd5,
		CMD_UVAR64 = 3'd6,
		CMD_SVAR64 = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [VALUE_W-1:0] word;
		logic [NB_W-1:0]    nbytes;
		logic               is_var;
	} item_t;

endpackage

// ----- rtl/vzs_front.sv -----
// Front end: byte order register and classification of each item.
`timescale 1ns / 1ps
module vzs_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_wdata,
	input  logic [2:0]               command,
	input  logic [vzs_pkg::VALUE_W-1:0] value,
	output vzs_pkg::item_t           item
);

	logic        big_endian_q;
	logic [63:0] zz32;
	logic [63:0] zz64;
	logic [63:0] var_word;
	logic [63:0] fix_word;
	logic [63:0] rev64;
	logic [9:1]  grp_nz;
	logic [3:0]  var_nb;
	vzs_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
		end else if (cfg_we) begin
			big_endian_q <= cfg_wdata;
		end
	end

	assign cmd  = vzs_pkg::cmd_t'(command);
	assign zz32 = {32'd0, {value[30:0], 1'b0} ^ {32{value[31]}}};
	assign zz64 = {value[62:0], 1'b0} ^ {64{value[63]}};

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			rev64[8*k +: 8] = value[8*(7-k) +: 8];
		end
	end

	always_comb begin
		case (cmd)
			vzs_pkg::CMD_UVAR32: var_word = {32'd0, value[31:0]};
			vzs_pkg::CMD_SVAR32: var_word = zz32;
			vzs_pkg::CMD_UVAR64: var_word = value;
			default:             var_word = zz64;
		endcase
	end

	always_comb begin
		for (int g = 1; g < 9; g++) begin
			grp_nz[g] = |var_word[7*g +: 7];
		end
		grp_nz[9] = var_word[63];
		var_nb = 4'd1;
		for (int g = 1; g < 10; g++) begin
			if (grp_nz[g]) begin
				var_nb = 4'(g + 1);
			end
		end
	end

	always_comb begin
		fix_word = value;
		if (big_endian_q) begin
			case (cmd)
				vzs_pkg::CMD_FIX16: fix_word = {48'd0, value[7:0], value[15:8]};
				vzs_pkg::CMD_FIX32: fix_word = {32'd0, value[7:0], value[15:8],
					value[23:16], value[31:24]};
				vzs_pkg::CMD_FIX64: fix_word = rev64;
				default:            fix_word = value;
			endcase
		end
	end

	always_comb begin
		item = '0;
		case (cmd)
			vzs_pkg::CMD_FIX8: begin
				item.word = fix_word;
				item.nbytes = 4'd1;
				item.is_var = 1'b0;
			end
			vzs_pkg::CMD_FIX16: begin
				item.word = fix_word;
				item.nbytes = 4'd2;
				item.is_var = 1'b0;
			end
			vzs_pkg::CMD_FIX32: begin
				item.word = fix_word;
				item.nbytes = 4'd4;
				item.is_var = 1'b0;
			end
			vzs_pkg::CMD_FIX64: begin
				item.word = fix_word;
				item.nbytes = 4'd8;
				item.is_var = 1'b0;
			end
			default: begin
				item.word = var_word;
				item.nbytes = var_nb;
				item.is_var = 1'b1;
			end
		endcase
	end

endmodule

// ----- rtl/vzs_queue.sv -----
// Short item queue between the front and back ends.
`timescale 1ns / 1ps
`include "varint_zigzag_serializer_macros.svh"
module vzs_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vzs_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output vzs_pkg::item_t head_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	vzs_pkg::item_t    entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				entry_q[i] <= '0;
			end
		end else begin
			if (push) begin
				entry_q[wr_ptr_q] <= push_item;
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`VZS_NEVER(a_no_overflow, push && full)
	`VZS_NEVER(a_no_underflow, pop && !not_empty)
	`VZS_ASSERT(a_count_tracks, push && !pop && !full |=> count_q == $past(count_q) + 1'b1)

endmodule

// ----- rtl/vzs_back.sv -----
// Back end: emits one byte per cycle from the queued items.
`timescale 1ns / 1ps
`include "varint_zigzag_serializer_macros.svh"
module vzs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  vzs_pkg::item_t q_item,
	output logic           q_pop,
	output logic           byte_valid,
	output logic [7:0]     out_byte,
	output logic           last_byte
);

	logic                         active_q;
	logic [vzs_pkg::VALUE_W-1:0]  word_q;
	logic [vzs_pkg::NB_W-1:0]     rem_q;
	logic                         var_q;
	logic                         byte_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         last_byte_q;
	logic                         final_byte;
	logic [7:0]                   cur_byte;

	assign final_byte = (rem_q == vzs_pkg::NB_W'(1));
	assign cur_byte   = var_q ? {!final_byte, word_q[6:0]} : word_q[7:0];
	assign q_pop      = q_valid && (!active_q || final_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			word_q       <= '0;
			rem_q        <= '0;
			var_q        <= 1'b0;
			byte_valid_q <= 1'b0;
			out_byte_q   <= '0;
			last_byte_q  <= 1'b0;
		end else begin
			byte_valid_q <= active_q;
			if (active_q) begin
				out_byte_q  <= cur_byte;
				last_byte_q <= final_byte;
			end
			if (q_pop) begin
				word_q   <= q_item.word;
				rem_q    <= q_item.nbytes;
				var_q    <= q_item.is_var;
				active_q <= 1'b1;
			end else if (active_q) begin
				word_q <= var_q ? (word_q >> 7) : (word_q >> 8);
				rem_q  <= rem_q - 1'b1;
				if (final_byte) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	assign byte_valid = byte_valid_q;
	assign out_byte   = out_byte_q;
	assign last_byte  = last_byte_q;

	`VZS_ASSERT(a_rem_range, active_q |-> rem_q != '0 && rem_q <= vzs_pkg::NB_W'(vzs_pkg::MAX_BYTES))
	`VZS_ASSERT(a_last_marked, active_q && final_byte |=> byte_valid_q && last_byte_q)
	`VZS_ASSERT(a_strobe_source, byte_valid_q |-> $past(active_q))

endmodule

// ----- rtl/varint_zigzag_serializer.sv -----
// Top level of the varint / zigzag serializer.
//
//   channel   ports                              handshake
//   item in   command, value                     start && !busy
//   byte out  out_byte, last_byte                byte_valid, one cycle, no stall
//   config    cfg_wdata (big_endian_order)       cfg_we
//
// An item is taken whenever the queue has room; the front end classifies it
// combinationally in that cycle. The back end sends one byte per cycle, so an
// item of 1 to 10 bytes holds it until all are sent; the byte channel sets the
// sustained rate. The first byte passes the queue, word and output registers.
// Reset empties the queue and sets big_endian_order to 1.
`timescale 1ns / 1ps
module varint_zigzag_serializer #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [63:0] value,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output logic        byte_valid,
	output logic [7:0]  out_byte,
	output logic        last_byte
);

	vzs_pkg::item_t front_item;
	vzs_pkg::item_t head_item;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;

	assign busy = q_full;

	vzs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.command   (command),
		.value     (value),
		.item      (front_item)
	);

	vzs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (start && !q_full),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head_item (head_item)
	);

	vzs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (head_item),
		.q_pop      (q_pop),
		.byte_valid (byte_valid),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

endmodule

// ----- tb/varint_zigzag_serializer_tb.sv -----
// Self-checking testbench of the varint / zigzag serializer.
`timescale 1ns / 1ps
module varint_zigzag_serializer_tb;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} serial_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  command = vzs_pkg::CMD_FIX8;
	logic [63:0] value = 64'd0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        byte_valid;
	logic [7:0]  out_byte;
	logic        last_byte;

	serial_byte_t pending_bytes[$];
	logic         msb_first = 1'b1;
	int unsigned  err_count = 0;
	int unsigned  items_sent = 0;
	int unsigned  bytes_checked = 0;
	int unsigned  sender_idle_pct = 0;

	always #4 clk = ~clk;

	varint_zigzag_serializer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.value      (value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.byte_valid (byte_valid),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

	function automatic void push_fixed(logic [63:0] v, int unsigned nbytes);
		int unsigned k;
		int unsigned pos;
		serial_byte_t e;
		for (k = 0; k < nbytes; k++) begin
			pos = msb_first ? (nbytes - 1 - k) : k;
			e.data = v[8*pos +: 8];
			e.last = (k == nbytes - 1);
			pending_bytes = {pending_bytes, e};
		end
	endfunction

	function automatic void push_varint(logic [63:0] x);
		int unsigned n;
		serial_byte_t e;
		n = 0;
		while (x >= 64'h80 && n < 9) begin
			e.data = {1'b1, x[6:0]};
			e.last = 1'b0;
			pending_bytes = {pending_bytes, e};
			x = x >> 7;
			n++;
		end
		e.data = x[7:0];
		e.last = 1'b1;
		pending_bytes = {pending_bytes, e};
	endfunction

	function automatic void serialize_value(logic [2:0] cmd, logic [63:0] v);
		logic [31:0] w;
		logic [31:0] z32;
		logic [63:0] z64;
		w = v[31:0];
		z32 = {w[30:0], 1'b0} ^ {32{w[31]}};
		z64 = {v[62:0], 1'b0} ^ {64{v[63]}};
		case (vzs_pkg::cmd_t'(cmd))
			vzs_pkg::CMD_FIX8:   push_fixed(v, 1);
			vzs_pkg::CMD_FIX16:  push_fixed(v, 2);
			vzs_pkg::CMD_FIX32:  push_fixed(v, 4);
			vzs_pkg::CMD_FIX64:  push_fixed(v, 8);
			vzs_pkg::CMD_UVAR32: push_varint({32'd0, w});
			vzs_pkg::CMD_SVAR32: push_varint({32'd0, z32});
			vzs_pkg::CMD_UVAR64: push_varint(v);
			default:             push_varint(z64);
		endcase
	endfunction

	always @(posedge clk) begin : check_bytes
		serial_byte_t e;
		if (arst_n) begin
			if (cfg_we)
				msb_first = cfg_wdata;
			if (start && !busy) begin
				serialize_value(command, value);
				items_sent++;
			end
			if (byte_valid) begin
				if (pending_bytes.size() == 0) begin
					$error("unexpected byte: out_byte %h last_byte %b", out_byte, last_byte);
					err_count++;
				end else begin
					e = pending_bytes.pop_front();
					bytes_checked++;
					if (out_byte !== e.data) begin
						$error("out_byte: expected %h, got %h", e.data, out_byte);
						err_count++;
					end
					if (last_byte !== e.last) begin
						$error("last_byte: expected %b, got %b", e.last, last_byte);
						err_count++;
					end
				end
			end
		end
	end

	task automatic send_item(input vzs_pkg::cmd_t c, input logic [63:0] v);
		start <= 1'b1;
		command <= c;
		value <= v;
		do @(posedge clk); while (busy);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
	endtask

	// hold off until every predicted byte is out
	task automatic wait_idle();
		start <= 1'b0;
		do @(negedge clk); while (pending_bytes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_order(input logic big_endian);
		cfg_we <= 1'b1;
		cfg_wdata <= big_endian;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] random_value();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(3))
			0:       return r;
			1:       return 64'($urandom_range(300));
			2:       return -64'($urandom_range(300, 1));
			default: return (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
		endcase
	endfunction

	task automatic test_fixed_formats();
		sender_idle_pct = 0;
		send_item(vzs_pkg::CMD_FIX8, 64'd0);
		send_item(vzs_pkg::CMD_FIX8, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(vzs_pkg::CMD_FIX16, 64'hAAAA_AAAA_AAAA_0102);
		send_item(vzs_pkg::CMD_FIX32, 64'h5555_5555_0102_0304);
		send_item(vzs_pkg::CMD_FIX64, 64'h0123_4567_89AB_CDEF);
		wait_idle();
		write_order(1'b0);
		send_item(vzs_pkg::CMD_FIX16, 64'hAAAA_AAAA_AAAA_0102);
		send_item(vzs_pkg::CMD_FIX32, 64'h5555_5555_0102_0304);
		send_item(vzs_pkg::CMD_FIX64, 64'h0123_4567_89AB_CDEF);
		wait_idle();
		write_order(1'b1);
	endtask

	task automatic test_varint_formats();
		sender_idle_pct = 0;
		send_item(vzs_pkg::CMD_UVAR32, 64'd0);
		send_item(vzs_pkg::CMD_UVAR32, 64'hDEAD_BEEF_0000_007F);
		send_item(vzs_pkg::CMD_UVAR32, 64'h0000_0000_0000_0080);
		send_item(vzs_pkg::CMD_UVAR32, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(vzs_pkg::CMD_SVAR32, 64'd0);
		send_item(vzs_pkg::CMD_SVAR32, 64'h0000_0000_FFFF_FFFF);
		send_item(vzs_pkg::CMD_SVAR32, 64'h0000_0000_8000_0000);
		send_item(vzs_pkg::CMD_SVAR32, 64'hFFFF_FFFF_7FFF_FFFF);
		send_item(vzs_pkg::CMD_UVAR64, 64'd0);
		send_item(vzs_pkg::CMD_UVAR64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(vzs_pkg::CMD_UVAR64, 64'h8000_0000_0000_0000);
		send_item(vzs_pkg::CMD_SVAR64, 64'h8000_0000_0000_0000);
		send_item(vzs_pkg::CMD_SVAR64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(vzs_pkg::CMD_SVAR64, 64'h7FFF_FFFF_FFFF_FFFF);
		wait_idle();
	endtask

	task automatic test_random_items(input int unsigned count, input int unsigned idle_pct,
			input logic big_endian);
		vzs_pkg::cmd_t c;
		logic [63:0]   v;
		wait_idle();
		write_order(big_endian);
		sender_idle_pct = idle_pct;
		repeat (count) begin
			c = vzs_pkg::cmd_t'($urandom_range(7));
			v = random_value();
			send_item(c, v);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);
		test_fixed_formats();
		test_varint_formats();
		test_random_items(95, 0, 1'b1);
		test_random_items(95, 59, 1'b0);
		test_random_items(95, 36, 1'b1);
		test_random_items(95, 0, 1'b0);
		wait_idle();
		repeat (16) @(posedge clk);
		$display("summary: %0d items, %0d bytes checked, all eight formats", items_sent,
			bytes_checked);
		$display("summary: both byte orders, sender gaps of 0, 36 and 59 percent");
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/vzs_pkg.sv
rtl/vzs_front.sv
rtl/vzs_queue.sv
rtl/vzs_back.sv
rtl/varint_zigzag_serializer.sv
tb/varint_zigzag_serializer_tb.sv
